[sv/tbcd_pkg.sv]
`default_nettype none
package tbcd_pkg;

   localparam int RAW_W   = 16;
   localparam int SIZE_W  = 13;
   localparam int COORD_W = 12;
   localparam int EDGE_W  = 12;
   localparam int ID_W    = 8;
   localparam int PROD_W  = RAW_W + SIZE_W;
   localparam int QUO_W   = SIZE_W;
   localparam int CSR_W   = 4;

   localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

   localparam logic [2:0] ACT_RAW_X   = 3'd0;
   localparam logic [2:0] ACT_RAW_Y   = 3'd1;
   localparam logic [2:0] ACT_PRESS   = 3'd2;
   localparam logic [2:0] ACT_RELEASE = 3'd3;
   localparam logic [2:0] ACT_WRITE   = 3'd4;

   localparam logic [CSR_W-1:0] CSR_RAW_X_MIN     = 4'd0;
   localparam logic [CSR_W-1:0] CSR_RAW_X_MAX     = 4'd1;
   localparam logic [CSR_W-1:0] CSR_RAW_Y_MIN     = 4'd2;
   localparam logic [CSR_W-1:0] CSR_RAW_Y_MAX     = 4'd3;
   localparam logic [CSR_W-1:0] CSR_SCREEN_WIDTH  = 4'd4;
   localparam logic [CSR_W-1:0] CSR_SCREEN_HEIGHT = 4'd5;
   localparam logic [CSR_W-1:0] CSR_ORIENTATION   = 4'd6;
   localparam logic [CSR_W-1:0] CSR_BUTTON_COUNT  = 4'd7;

   typedef struct packed {
      logic [2:0]        action;
      logic [RAW_W-1:0]  raw_value;
      logic [3:0]        entry_index;
      logic [EDGE_W-1:0] entry_left;
      logic [EDGE_W-1:0] entry_top;
      logic [EDGE_W-1:0] entry_width;
      logic [EDGE_W-1:0] entry_height;
      logic [ID_W-1:0]   entry_id;
   } tbcd_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] screen_x;
      logic [COORD_W-1:0] screen_y;
      logic               highlight_valid;
      logic [3:0]         highlight_index;
      logic               repaint;
      logic               click_valid;
      logic [ID_W-1:0]    click_id;
   } tbcd_rsp_type;

   typedef struct packed {
      logic [EDGE_W-1:0] left;
      logic [EDGE_W-1:0] top;
      logic [EDGE_W-1:0] width;
      logic [EDGE_W-1:0] height;
      logic [ID_W-1:0]   id;
   } tbcd_button_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ORIENT,
      ST_SCAN,
      ST_REL_READ,
      ST_REL_DATA,
      ST_DONE
   } tbcd_state_type;

endpackage
`default_nettype wire

[sv/tbcd_div.sv]
`default_nettype none
module tbcd_div
   import tbcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [RAW_W-1:0]  divisor,
   output logic                   done,
   output logic [QUO_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [RAW_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [RAW_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAW_W:0]   trial;

   // upper dividend bits are below the divisor, so QUO_W steps suffice
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, low_ff[QUO_W-1]};
      if (start) begin
         rem_in  = dividend[PROD_W-1:QUO_W];
         low_in  = dividend[QUO_W-1:0];
         quo_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = RAW_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[RAW_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[sv/touch_button_click_detector_core.sv]
`default_nettype none
// Touch button click detector. One request beat carries a raw X or Y value, a press,
// a release or a button-table write; each produces exactly one response beat with the
// mapped screen coordinates, the highlight and any click. Coordinate events and presses
// remap both axes through one shared 16x13 multiplier and a radix-2 divider; the divider
// is skipped for an axis with an empty range. When the finger is down or on a press,
// the block then scans the button table, kept in a memory with separate write and
// read ports, at one entry per cycle. The scan covers up to min(button_count,
// MAX_BUTTONS) entries. The next request beat can be taken in the cycle the response
// is presented, or later while the previous response is still held. The table is
// undefined until written. Configuration writes go through csr_we/csr_index/csr_wdata;
// the user must issue them only while idle, as the block itself does not enforce
// this.
module touch_button_click_detector_core
   import tbcd_pkg::*;
#(
   parameter int MAX_BUTTONS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tbcd_req_type      req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tbcd_rsp_type           rsp_data,
   input  wire logic              csr_we,
   input  wire logic [CSR_W-1:0]  csr_index,
   input  wire logic [RAW_W-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
   localparam int CNT_W = $clog2(MAX_BUTTONS + 1);

   // configuration
   logic [RAW_W-1:0]  x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [2:0]        orient_ff;
   logic [4:0]        count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff  <= '0;
         x_max_ff  <= RAW_W'(4095);
         y_min_ff  <= '0;
         y_max_ff  <= RAW_W'(4095);
         width_ff  <= SIZE_W'(800);
         height_ff <= SIZE_W'(480);
         orient_ff <= '0;
         count_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RAW_X_MIN:     x_min_ff  <= csr_wdata;
            CSR_RAW_X_MAX:     x_max_ff  <= csr_wdata;
            CSR_RAW_Y_MIN:     y_min_ff  <= csr_wdata;
            CSR_RAW_Y_MAX:     y_max_ff  <= csr_wdata;
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_ORIENTATION:   orient_ff <= csr_wdata[2:0];
            CSR_BUTTON_COUNT:  count_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // state
   tbcd_state_type     state_ff, state_in;
   tbcd_req_type       req_ff;
   logic [RAW_W-1:0]   raw_x_ff, raw_y_ff;
   logic [COORD_W-1:0] map_x_ff, map_y_ff;
   logic               finger_ff;
   logic               hl_valid_ff;
   logic [IDX_W-1:0]   hl_idx_ff;
   logic               axis_ff;
   logic               empty_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [RAW_W-1:0]   range_ff;
   logic [QUO_W-1:0]   scl_x_ff, scl_y_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic               repaint_ff, click_ff;
   logic [ID_W-1:0]    click_id_ff;
   logic               rsp_valid_ff;
   tbcd_rsp_type       rsp_ff;

   // button table
   tbcd_button_type    table_mem [MAX_BUTTONS];
   tbcd_button_type    rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;

   assign wr_en   = (state_ff == ST_DECODE) && (req_ff.action == ACT_WRITE) &&
                    (8'(req_ff.entry_index) < 8'(MAX_BUTTONS));
   assign wr_addr = IDX_W'(req_ff.entry_index);
   assign rd_addr = (state_ff == ST_REL_READ) ? hl_idx_ff : ptr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= '{left:   req_ff.entry_left,
                                 top:    req_ff.entry_top,
                                 width:  req_ff.entry_width,
                                 height: req_ff.entry_height,
                                 id:     req_ff.entry_id};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // axis scaling operands
   logic [RAW_W-1:0]  ax_v, ax_lo, ax_hi, ax_vc;
   logic [SIZE_W-1:0] om_x, om_y, ax_om;
   logic              div_start, div_done;
   logic [QUO_W-1:0]  div_q;

   assign om_x  = (width_ff == '0) ? '0 : width_ff - 1'b1;
   assign om_y  = (height_ff == '0) ? '0 : height_ff - 1'b1;
   assign ax_v  = axis_ff ? raw_y_ff : raw_x_ff;
   assign ax_lo = axis_ff ? y_min_ff : x_min_ff;
   assign ax_hi = axis_ff ? y_max_ff : x_max_ff;
   assign ax_om = axis_ff ? om_y : om_x;
   assign ax_vc = (ax_v < ax_lo) ? ax_lo : ((ax_v > ax_hi) ? ax_hi : ax_v);

   assign div_start = (state_ff == ST_DIV_START) && !empty_ff;

   tbcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (range_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // swap, mirror, saturate
   logic [QUO_W-1:0]   sw_x, sw_y, mr_x, mr_y;
   logic [COORD_W-1:0] fin_x, fin_y;

   always_comb begin
      sw_x = orient_ff[0] ? scl_y_ff : scl_x_ff;
      sw_y = orient_ff[0] ? scl_x_ff : scl_y_ff;
      mr_x = sw_x;
      mr_y = sw_y;
      if (orient_ff[1]) mr_x = (sw_x > om_x) ? '0 : om_x - sw_x;
      if (orient_ff[2]) mr_y = (sw_y > om_y) ? '0 : om_y - sw_y;
      fin_x = (mr_x > QUO_W'(COORD_MAX)) ? COORD_MAX : mr_x[COORD_W-1:0];
      fin_y = (mr_y > QUO_W'(COORD_MAX)) ? COORD_MAX : mr_y[COORD_W-1:0];
   end

   // table scan: compare the entry read last cycle while issuing the next read
   logic [7:0] scan_n;
   logic       more, hit, scan_done, changed;

   assign scan_n = (8'(count_ff) > 8'(MAX_BUTTONS)) ? 8'(MAX_BUTTONS) : 8'(count_ff);
   assign more   = 8'(ptr_ff) < scan_n;
   assign hit    = pend_ff &&
                   ({1'b0, map_x_ff} >= {1'b0, rd_data_ff.left}) &&
                   ({1'b0, map_x_ff} <= {1'b0, rd_data_ff.left} + {1'b0, rd_data_ff.width}) &&
                   ({1'b0, map_y_ff} >= {1'b0, rd_data_ff.top}) &&
                   ({1'b0, map_y_ff} <= {1'b0, rd_data_ff.top} + {1'b0, rd_data_ff.height});
   assign scan_done = hit || !more;
   assign changed   = (hit != hl_valid_ff) || (hit && (pend_idx_ff != hl_idx_ff));

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (req_ff.action)
               ACT_RAW_X, ACT_RAW_Y, ACT_PRESS: state_in = ST_MUL;
               ACT_RELEASE:                     state_in = ST_REL_READ;
               default:                         state_in = ST_DONE;
            endcase
         end
         ST_MUL:       state_in = ST_DIV_START;
         ST_DIV_START: begin
            if (empty_ff) state_in = axis_ff ? ST_ORIENT : ST_MUL;
            else          state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT:  if (div_done) state_in = axis_ff ? ST_ORIENT : ST_MUL;
         ST_ORIENT:    state_in = (finger_ff || (req_ff.action == ACT_PRESS)) ? ST_SCAN : ST_DONE;
         ST_SCAN:      if (scan_done) state_in = ST_DONE;
         ST_REL_READ:  state_in = ST_REL_DATA;
         ST_REL_DATA:  state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         raw_x_ff     <= '0;
         raw_y_ff     <= '0;
         map_x_ff     <= '0;
         map_y_ff     <= '0;
         finger_ff    <= 1'b0;
         hl_valid_ff  <= 1'b0;
         hl_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         ptr_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                    rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) req_ff <= req_data;
            end
            ST_DECODE: begin
               repaint_ff  <= 1'b0;
               click_ff    <= 1'b0;
               click_id_ff <= '0;
               axis_ff     <= 1'b0;
               if (req_ff.action == ACT_RAW_X) raw_x_ff <= req_ff.raw_value;
               if (req_ff.action == ACT_RAW_Y) raw_y_ff <= req_ff.raw_value;
               if (req_ff.action == ACT_PRESS) finger_ff <= 1'b1;
            end
            ST_MUL: begin
               prod_ff  <= PROD_W'(ax_vc - ax_lo) * PROD_W'(ax_om);
               range_ff <= ax_hi - ax_lo;
               empty_ff <= (ax_hi <= ax_lo);
            end
            ST_DIV_START: begin
               if (empty_ff) begin
                  if (axis_ff) scl_y_ff <= '0;
                  else         scl_x_ff <= '0;
                  axis_ff <= 1'b1;
               end
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  if (axis_ff) scl_y_ff <= div_q;
                  else         scl_x_ff <= div_q;
                  axis_ff <= 1'b1;
               end
            end
            ST_ORIENT: begin
               map_x_ff <= fin_x;
               map_y_ff <= fin_y;
               ptr_ff   <= '0;
               pend_ff  <= 1'b0;
            end
            ST_SCAN: begin
               if (scan_done) begin
                  pend_ff <= 1'b0;
                  if (req_ff.action == ACT_PRESS) begin
                     hl_valid_ff <= hit;
                     hl_idx_ff   <= hit ? pend_idx_ff : '0;
                     repaint_ff  <= 1'b1;
                  end else if (changed) begin
                     hl_valid_ff <= hit;
                     hl_idx_ff   <= hit ? pend_idx_ff : '0;
                     repaint_ff  <= 1'b1;
                  end
               end else begin
                  // issue the next read
                  pend_ff     <= 1'b1;
                  pend_idx_ff <= ptr_ff[IDX_W-1:0];
                  ptr_ff      <= ptr_ff + 1'b1;
               end
            end
            ST_REL_DATA: begin
               finger_ff   <= 1'b0;
               hl_valid_ff <= 1'b0;
               hl_idx_ff   <= '0;
               repaint_ff  <= 1'b1;
               if (hl_valid_ff) begin
                  click_ff    <= 1'b1;
                  click_id_ff <= rd_data_ff.id;
                  raw_x_ff    <= '0;
                  raw_y_ff    <= '0;
                  map_x_ff    <= '0;
                  map_y_ff    <= '0;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_ff <= '{screen_x:        map_x_ff,
                              screen_y:        map_y_ff,
                              highlight_valid: hl_valid_ff,
                              highlight_index: hl_valid_ff ? 4'(hl_idx_ff) : 4'd0,
                              repaint:         repaint_ff,
                              click_valid:     click_ff,
                              click_id:        click_id_ff};
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
